/* rtl/mlu_pkg.sv */
// Package for the mutex lock unit: field widths, request and status codes,
// and the command struct from the controller to the datapath. No dependencies.
package mlu_pkg;

  localparam int FUNC_W   = 2;
  localparam int MID_W    = 4;
  localparam int TID_W    = 8;
  localparam int STATUS_W = 4;

  localparam logic [FUNC_W-1:0] FUNC_CREATE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOCK   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_UNLOCK = 2'd2;

  localparam logic [STATUS_W-1:0] ST_CREATED   = 4'd0;
  localparam logic [STATUS_W-1:0] ST_EXISTS    = 4'd1;
  localparam logic [STATUS_W-1:0] ST_GRANTED   = 4'd2;
  localparam logic [STATUS_W-1:0] ST_BLOCKED   = 4'd3;
  localparam logic [STATUS_W-1:0] ST_NO_MUTEX  = 4'd4;
  localparam logic [STATUS_W-1:0] ST_NOT_OWNER = 4'd5;
  localparam logic [STATUS_W-1:0] ST_FREED     = 4'd6;
  localparam logic [STATUS_W-1:0] ST_HANDED    = 4'd7;
  localparam logic [STATUS_W-1:0] ST_QFULL     = 4'd8;

  typedef struct packed {
    logic load;    // latch request word, start waiter read
    logic commit;  // update table, load result register
  } mlu_cmd_t;

endpackage

/* rtl/mlu_req_if.sv */
// Request channel of the mutex lock unit: valid, ready and the request word.
// Depends on mlu_pkg.
interface mlu_req_if import mlu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [MID_W-1:0]  mutex_id;
  logic [TID_W-1:0]  thread_id;

  modport source (output valid, func, mutex_id, thread_id, input ready);
  modport sink   (input valid, func, mutex_id, thread_id, output ready);
endinterface

/* rtl/mlu_rsp_if.sv */
// Result channel of the mutex lock unit: valid, ready and the result word.
// Depends on mlu_pkg.
interface mlu_rsp_if import mlu_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [TID_W-1:0]    next_owner;
  logic                next_owner_valid;

  modport source (output valid, status, next_owner, next_owner_valid, input ready);
  modport sink   (input valid, status, next_owner, next_owner_valid, output ready);
endinterface

/* rtl/mlu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mlu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/mlu_ctrl.sv */
// Controller of the mutex lock unit: two-state sequencer and result valid.
// Depends on mlu_pkg.
module mlu_ctrl import mlu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output mlu_cmd_t cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_free     = !out_valid_q || out_ready_i;
  assign cmd_o.load   = in_valid_i && (state_q == S_IDLE);
  assign cmd_o.commit = (state_q == S_EXEC) && out_free;
  assign out_valid_o  = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_EXEC;
      S_EXEC: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* rtl/mlu_dp.sv */
// Datapath of the mutex lock unit: per-mutex table, waiter RAM, result word.
// Depends on mlu_pkg and mlu_ram.
module mlu_dp import mlu_pkg::*; #(
  parameter int NUM_MUTEXES    = 16,
  parameter int QUEUE_DEPTH    = 16,
  parameter int THREAD_ID_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mlu_cmd_t            cmd_i,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [MID_W-1:0]    mutex_id_i,
  input  logic [TID_W-1:0]    thread_id_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [TID_W-1:0]    next_owner_o,
  output logic                next_owner_valid_o
);

  localparam int MW = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1;
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LW = $clog2(QUEUE_DEPTH + 1);
  localparam int TW = (THREAD_ID_BITS < TID_W) ? THREAD_ID_BITS : TID_W;
  localparam int RAM_DEPTH = NUM_MUTEXES * QUEUE_DEPTH;
  localparam int AW = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

  // request word
  logic [FUNC_W-1:0] func_q;
  logic [MID_W-1:0]  mid_q;
  logic [TW-1:0]     tid_q;

  // mutex table
  logic          exists_q [NUM_MUTEXES];
  logic          held_q   [NUM_MUTEXES];
  logic [TW-1:0] owner_q  [NUM_MUTEXES];
  logic [QW-1:0] head_q   [NUM_MUTEXES];
  logic [LW-1:0] len_q    [NUM_MUTEXES];

  // result word
  logic [STATUS_W-1:0] status_q, status_d;
  logic [TID_W-1:0]    woken_q, woken_d;
  logic                woken_vld_q, woken_vld_d;

  logic [MW+MID_W-1:0] in_ext, ex_ext;
  logic                in_hit, ex_hit;
  logic [MW-1:0]       in_idx, ex_idx;
  logic [AW-1:0]       raddr, waddr;
  logic [TW-1:0]       rdata;

  logic          cur_exists, cur_held;
  logic [TW-1:0] cur_owner;
  logic [QW-1:0] cur_head, head_next, slot;
  logic [LW-1:0] cur_len;
  int unsigned   tail_sum;
  logic          do_create, do_grant, do_enq, do_free, do_hand;

  assign in_ext = (MW + MID_W)'(mutex_id_i);
  assign ex_ext = (MW + MID_W)'(mid_q);
  assign in_hit = (32'(mutex_id_i) < NUM_MUTEXES);
  assign ex_hit = (32'(mid_q) < NUM_MUTEXES);
  assign in_idx = in_hit ? in_ext[MW-1:0] : '0;
  assign ex_idx = ex_hit ? ex_ext[MW-1:0] : '0;

  assign raddr = AW'(32'(in_idx) * QUEUE_DEPTH + 32'(head_q[in_idx]));

  always_comb begin
    cur_exists = ex_hit && exists_q[ex_idx];
    cur_held   = held_q[ex_idx];
    cur_owner  = owner_q[ex_idx];
    cur_head   = head_q[ex_idx];
    cur_len    = len_q[ex_idx];
    tail_sum   = 32'(cur_head) + 32'(cur_len);
    slot       = (tail_sum >= QUEUE_DEPTH) ? QW'(tail_sum - QUEUE_DEPTH) : QW'(tail_sum);
    head_next  = (32'(cur_head) + 1 >= QUEUE_DEPTH) ? '0 : QW'(32'(cur_head) + 1);
    waddr      = AW'(32'(ex_idx) * QUEUE_DEPTH + 32'(slot));
  end

  always_comb begin
    status_d    = ST_NO_MUTEX;
    woken_d     = '0;
    woken_vld_d = 1'b0;
    do_create   = 1'b0;
    do_grant    = 1'b0;
    do_enq      = 1'b0;
    do_free     = 1'b0;
    do_hand     = 1'b0;
    unique case (func_q)
      FUNC_CREATE: begin
        if (ex_hit) begin
          if (exists_q[ex_idx]) begin
            status_d = ST_EXISTS;
          end else begin
            status_d  = ST_CREATED;
            do_create = 1'b1;
          end
        end
      end
      FUNC_LOCK: begin
        if (cur_exists) begin
          if (!cur_held) begin
            status_d = ST_GRANTED;
            do_grant = 1'b1;
          end else if (32'(cur_len) >= QUEUE_DEPTH) begin
            status_d = ST_QFULL;
          end else begin
            status_d = ST_BLOCKED;
            do_enq   = 1'b1;
          end
        end
      end
      FUNC_UNLOCK: begin
        if (cur_exists) begin
          if (!cur_held || (cur_owner != tid_q)) begin
            status_d = ST_NOT_OWNER;
          end else if (cur_len == '0) begin
            status_d = ST_FREED;
            do_free  = 1'b1;
          end else begin
            status_d    = ST_HANDED;
            woken_d     = TID_W'(rdata);
            woken_vld_d = 1'b1;
            do_hand     = 1'b1;
          end
        end
      end
      default: status_d = ST_NO_MUTEX;
    endcase
  end

  mlu_ram #(
    .WIDTH (TW),
    .DEPTH (RAM_DEPTH)
  ) u_waiters (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit && do_enq),
    .waddr_i (waddr),
    .wdata_i (tid_q),
    .re_i    (cmd_i.load),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      mid_q  <= mutex_id_i;
      tid_q  <= thread_id_i[TW-1:0];
    end
    if (cmd_i.commit) begin
      status_q    <= status_d;
      woken_q     <= woken_d;
      woken_vld_q <= woken_vld_d;
      if (do_grant) begin
        owner_q[ex_idx] <= tid_q;
      end else if (do_hand) begin
        owner_q[ex_idx] <= rdata;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_MUTEXES; i++) begin
        exists_q[i] <= 1'b0;
        held_q[i]   <= 1'b0;
        head_q[i]   <= '0;
        len_q[i]    <= '0;
      end
    end else if (cmd_i.commit) begin
      if (do_create) begin
        exists_q[ex_idx] <= 1'b1;
        held_q[ex_idx]   <= 1'b0;
        head_q[ex_idx]   <= '0;
        len_q[ex_idx]    <= '0;
      end
      if (do_grant) held_q[ex_idx] <= 1'b1;
      if (do_free)  held_q[ex_idx] <= 1'b0;
      if (do_enq)   len_q[ex_idx]  <= LW'(32'(cur_len) + 1);
      if (do_hand) begin
        head_q[ex_idx] <= head_next;
        len_q[ex_idx]  <= LW'(32'(cur_len) - 1);
      end
    end
  end

  assign status_o           = status_q;
  assign next_owner_o       = woken_q;
  assign next_owner_valid_o = woken_vld_q;

endmodule

/* rtl/mutex_lock_unit_fifo_waiters.sv */
// Top level of the mutex lock unit with FIFO wait queues.
// Depends on mlu_pkg, mlu_req_if, mlu_rsp_if, mlu_ctrl, mlu_dp (and mlu_ram).
//
//   channel  dir  fields                                   accepted when
//   req_i    in   func, mutex_id, thread_id                valid && ready
//   rsp_o    out  status, next_owner, next_owner_valid     valid && ready
//
// Each request is accepted together with the waiter RAM read; the table update follows
// once the registered read data of the waiter RAM is available.
// Reset clears the exists, owner-held, head and length flops at once; the
// waiter RAM and owner ids need no clearing.
// A result waiting in the output register holds the update cycle of the
// next request until it is taken.
module mutex_lock_unit_fifo_waiters import mlu_pkg::*; #(
  parameter int NUM_MUTEXES    = 16,
  parameter int QUEUE_DEPTH    = 16,
  parameter int THREAD_ID_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mlu_req_if.sink     req_i,
  mlu_rsp_if.source   rsp_o
);

  mlu_cmd_t cmd;

  mlu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  mlu_dp #(
    .NUM_MUTEXES    (NUM_MUTEXES),
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .THREAD_ID_BITS (THREAD_ID_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .func_i             (req_i.func),
    .mutex_id_i         (req_i.mutex_id),
    .thread_id_i        (req_i.thread_id),
    .status_o           (rsp_o.status),
    .next_owner_o       (rsp_o.next_owner),
    .next_owner_valid_o (rsp_o.next_owner_valid)
  );

endmodule
